/* src/assert_macros.svh */
// Assertion macros shared by the tokenizer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/stok_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the script tokenizer.
// Used by stok_scan and script_tokenizer_core; depends on nothing.
package stok_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] ChLbrace  = 8'h7B;
  localparam logic [7:0] ChRbrace  = 8'h7D;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChEnd     = 8'h00;

  localparam logic [1:0] KindWord  = 2'd0;
  localparam logic [1:0] KindQuote = 2'd1;
  localparam logic [1:0] KindBrace = 2'd2;

  localparam logic [7:0] MaxCharsReset = 8'd255;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic [1:0] kind;
    logic       tok_end;
    logic       done;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [2:0]            cnt;
  } step_t;

endpackage

/* src/stok_scan.sv */
`timescale 1ns / 1ps
// Scanner state and per-byte result list of the script tokenizer.
// Depends on stok_pkg.
module stok_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     text_byte_i,
  input  logic [7:0]     max_chars_i,
  output stok_pkg::step_t step_o
);
  import stok_pkg::*;

  typedef enum logic [2:0] {
    ModeIdle,
    ModeSlash,
    ModeLine,
    ModeBlock,
    ModeBlockStar,
    ModeWord,
    ModeQuote
  } mode_e;

  mode_e        mode_q, mode_d;
  logic [7:0]   kept_q, kept_d;
  logic [2:0]   n_v;
  res_t [MaxResults-1:0] res_v;
  logic         do_word, do_start;
  logic [7:0]   b;

  function automatic res_t make_res(logic [7:0] ch, logic has, logic [1:0] kind,
                                    logic tok_end, logic done);
    res_t r;
    r.ch       = ch;
    r.has_char = has;
    r.kind     = kind;
    r.tok_end  = tok_end;
    r.done     = done;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return ((c >= ChTab) && (c <= ChCr)) || (c == ChSpace);
  endfunction

  assign b = text_byte_i;

  always_comb begin
    mode_d   = mode_q;
    kept_d   = kept_q;
    n_v      = '0;
    res_v    = '0;
    do_word  = 1'b0;
    do_start = 1'b0;

    unique case (mode_q)
      ModeSlash: begin
        if (b == ChSlash) begin
          mode_d = ModeLine;
        end else if (b == ChStar) begin
          mode_d = ModeBlock;
        end else begin
          kept_d = '0;
          mode_d = ModeWord;
          if (kept_d < max_chars_i) begin
            res_v[n_v[1:0]] = make_res(ChSlash, 1'b1, KindWord, 1'b0, 1'b0);
            n_v    = n_v + 3'd1;
            kept_d = kept_d + 8'd1;
          end
          do_word = 1'b1;
        end
      end
      ModeLine: begin
        if (b == ChEnd) begin
          res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindWord, 1'b0, 1'b1);
          n_v    = n_v + 3'd1;
          mode_d = ModeIdle;
          kept_d = '0;
        end else if (b == ChNewline) begin
          mode_d = ModeIdle;
        end
      end
      ModeBlock: begin
        if (b == ChEnd) begin
          res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindWord, 1'b0, 1'b1);
          n_v    = n_v + 3'd1;
          mode_d = ModeIdle;
          kept_d = '0;
        end else if (b == ChStar) begin
          mode_d = ModeBlockStar;
        end
      end
      ModeBlockStar: begin
        if (b == ChEnd) begin
          res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindWord, 1'b0, 1'b1);
          n_v    = n_v + 3'd1;
          mode_d = ModeIdle;
          kept_d = '0;
        end else if (b == ChSlash) begin
          mode_d = ModeIdle;
        end else if (b != ChStar) begin
          mode_d = ModeBlock;
        end
      end
      ModeWord: begin
        do_word = 1'b1;
      end
      ModeQuote: begin
        if (b == ChEnd) begin
          res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindQuote, 1'b1, 1'b0);
          n_v = n_v + 3'd1;
          res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindWord, 1'b0, 1'b1);
          n_v    = n_v + 3'd1;
          mode_d = ModeIdle;
          kept_d = '0;
        end else if ((b == ChQuote) || (b == ChNewline)) begin
          res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindQuote, 1'b1, 1'b0);
          n_v    = n_v + 3'd1;
          mode_d = ModeIdle;
        end else if (kept_d < max_chars_i) begin
          res_v[n_v[1:0]] = make_res(b, 1'b1, KindQuote, 1'b0, 1'b0);
          n_v    = n_v + 3'd1;
          kept_d = kept_d + 8'd1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // A word ends at whitespace, a brace or a quote; that byte then opens the next token.
    if (do_word) begin
      if (b == ChEnd) begin
        res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindWord, 1'b1, 1'b0);
        n_v = n_v + 3'd1;
        res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindWord, 1'b0, 1'b1);
        n_v    = n_v + 3'd1;
        mode_d = ModeIdle;
        kept_d = '0;
      end else if (is_space(b) || (b == ChLbrace) || (b == ChRbrace) || (b == ChQuote)) begin
        res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindWord, 1'b1, 1'b0);
        n_v      = n_v + 3'd1;
        mode_d   = ModeIdle;
        do_start = 1'b1;
      end else if (kept_d < max_chars_i) begin
        res_v[n_v[1:0]] = make_res(b, 1'b1, KindWord, 1'b0, 1'b0);
        n_v    = n_v + 3'd1;
        kept_d = kept_d + 8'd1;
      end
    end

    if (do_start) begin
      if (b == ChEnd) begin
        res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindWord, 1'b0, 1'b1);
        n_v    = n_v + 3'd1;
        mode_d = ModeIdle;
        kept_d = '0;
      end else if (is_space(b)) begin
        mode_d = ModeIdle;
      end else if (b == ChSlash) begin
        mode_d = ModeSlash;
      end else if ((b == ChLbrace) || (b == ChRbrace)) begin
        res_v[n_v[1:0]] = make_res(b, 1'b1, KindBrace, 1'b0, 1'b0);
        n_v = n_v + 3'd1;
        res_v[n_v[1:0]] = make_res(ChEnd, 1'b0, KindBrace, 1'b1, 1'b0);
        n_v    = n_v + 3'd1;
        mode_d = ModeIdle;
      end else if (b == ChQuote) begin
        kept_d = '0;
        mode_d = ModeQuote;
      end else begin
        kept_d = '0;
        mode_d = ModeWord;
        if (kept_d < max_chars_i) begin
          res_v[n_v[1:0]] = make_res(b, 1'b1, KindWord, 1'b0, 1'b0);
          n_v    = n_v + 3'd1;
          kept_d = kept_d + 8'd1;
        end
      end
    end

    if (n_v != 3'd0) begin
      res_v[n_v[1:0] - 2'd1].last = 1'b1;
    end

    step_o.res = res_v;
    step_o.cnt = n_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      kept_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      kept_q <= kept_d;
    end
  end

endmodule

/* src/script_tokenizer_core.sv */
`timescale 1ns / 1ps
// Channel     | Signals                                      | Direction
// text in     | in_valid_i, in_stall_o, text_byte_i          | request in
// result out  | out_valid_o, out_stall_i, token_char_o ...   | request out
// config      | cfg_we_i, cfg_wdata_i (max_token_chars)      | write only
// A byte is scanned in the cycle it is accepted and its results appear from the next cycle.
// While out_stall_i is low, results leave one per cycle from a four-entry result buffer;
// a byte with n results holds the input until its last result leaves, others flow one per
// cycle. Reset returns the scanner to idle between tokens and sets the limit to 255.
// Top level of the script tokenizer; depends on stok_pkg and stok_scan.
`include "assert_macros.svh"
module script_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] token_char_o,
  output logic       has_char_o,
  output logic [1:0] token_kind_o,
  output logic       token_end_o,
  output logic       stream_done_o,
  output logic       last_of_step_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  import stok_pkg::*;

  logic [7:0]            max_chars_q;
  res_t [MaxResults-1:0] buf_q, buf_d;
  logic [2:0]            cnt_q, cnt_d;
  logic                  in_accept, pop;
  step_t                 step;

  assign pop        = (cnt_q != 3'd0) && !out_stall_i;
  assign in_stall_o = !((cnt_q == 3'd0) || ((cnt_q == 3'd1) && !out_stall_i));
  assign in_accept  = in_valid_i && !in_stall_o;

  stok_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .text_byte_i (text_byte_i),
    .max_chars_i (max_chars_q),
    .step_o      (step)
  );

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (in_accept) begin
      buf_d = step.res;
      cnt_d = step.cnt;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      max_chars_q <= MaxCharsReset;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        max_chars_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign out_valid_o    = (cnt_q != 3'd0);
  assign token_char_o   = buf_q[0].ch;
  assign has_char_o     = buf_q[0].has_char;
  assign token_kind_o   = buf_q[0].kind;
  assign token_end_o    = buf_q[0].tok_end;
  assign stream_done_o  = buf_q[0].done;
  assign last_of_step_o = buf_q[0].last;

  `ASSERT_IMPLY(a_done_is_last, out_valid_o && stream_done_o, last_of_step_o && !has_char_o, "Done result must close its step and carry no character.")
  `ASSERT_IMPLY(a_end_no_char, out_valid_o && token_end_o, !has_char_o && !stream_done_o, "Token end result must carry no character.")
  `ASSERT_NEXT(a_step_contiguous, out_valid_o && !last_of_step_o, out_valid_o, "Results of one byte must follow each other without a gap.")
  `ASSERT_NEXT(a_drain_empty, out_valid_o && !out_stall_i && last_of_step_o && !in_accept, !out_valid_o, "Buffer must be empty after the last result leaves.")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for script_tokenizer_core: a directed table, then random text.
// Its own scanner model predicts all but the typed rows; depends on stok_pkg and the RTL.
module tb_top;
  import stok_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned MaxPrinted = 30;
  localparam res_t NoRes = '0;

  typedef enum logic [2:0] {
    ScIdle, ScSlash, ScLine, ScBlock, ScBlockStar, ScWord, ScQuote
  } scan_e;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [2:0] n;
    res_t       r0;
    res_t       r1;
  } dir_row_t;

  // Rows marked typed carry their results; the others are left to the scanner model.
  localparam dir_row_t DirRows [25] = '{
    {ChLbrace, 1'b1, 3'd2, {ChLbrace, 1'b1, KindBrace, 1'b0, 1'b0, 1'b0},
                           {ChEnd, 1'b0, KindBrace, 1'b1, 1'b0, 1'b1}},
    {ChRbrace, 1'b1, 3'd2, {ChRbrace, 1'b1, KindBrace, 1'b0, 1'b0, 1'b0},
                           {ChEnd, 1'b0, KindBrace, 1'b1, 1'b0, 1'b1}},
    {ChEnd,    1'b1, 3'd1, {ChEnd, 1'b0, KindWord, 1'b0, 1'b1, 1'b1}, NoRes},
    {ChQuote,  1'b1, 3'd0, NoRes, NoRes},
    {ChQuote,  1'b1, 3'd1, {ChEnd, 1'b0, KindQuote, 1'b1, 1'b0, 1'b1}, NoRes},
    {ChSlash,  1'b1, 3'd0, NoRes, NoRes},
    {8'h78,     1'b0, 3'd0, NoRes, NoRes},
    {ChSlash,   1'b0, 3'd0, NoRes, NoRes},
    {8'hFF,     1'b0, 3'd0, NoRes, NoRes},
    {ChQuote,   1'b0, 3'd0, NoRes, NoRes},
    {8'h01,     1'b0, 3'd0, NoRes, NoRes},
    {ChNewline, 1'b0, 3'd0, NoRes, NoRes},
    {ChSlash,   1'b0, 3'd0, NoRes, NoRes},
    {ChStar,    1'b0, 3'd0, NoRes, NoRes},
    {ChSlash,   1'b0, 3'd0, NoRes, NoRes},
    {ChStar,    1'b0, 3'd0, NoRes, NoRes},
    {ChStar,    1'b0, 3'd0, NoRes, NoRes},
    {ChSlash,   1'b0, 3'd0, NoRes, NoRes},
    {ChSlash,   1'b0, 3'd0, NoRes, NoRes},
    {ChSlash,   1'b0, 3'd0, NoRes, NoRes},
    {8'h71,     1'b0, 3'd0, NoRes, NoRes},
    {ChNewline, 1'b0, 3'd0, NoRes, NoRes},
    {ChTab,     1'b0, 3'd0, NoRes, NoRes},
    {ChSlash,   1'b0, 3'd0, NoRes, NoRes},
    {ChEnd,     1'b0, 3'd0, NoRes, NoRes}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] token_char_o;
  logic       has_char_o;
  logic [1:0] token_kind_o;
  logic       token_end_o;
  logic       stream_done_o;
  logic       last_of_step_o;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  scan_e       scan_st = ScIdle;
  logic [7:0]  kept_cnt = '0;
  logic [7:0]  char_limit = MaxCharsReset;
  res_t        step_res[$];
  res_t        tok_exp_q[$];

  int unsigned tx_pct = 0;
  int unsigned rx_pct = 0;
  logic        hold_long = 1'b0;
  int unsigned byte_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned tok_cnt = 0;
  int unsigned buf_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;

  script_tokenizer_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_char_o   (token_char_o),
    .has_char_o     (has_char_o),
    .token_kind_o   (token_kind_o),
    .token_end_o    (token_end_o),
    .stream_done_o  (stream_done_o),
    .last_of_step_o (last_of_step_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic is_ws(logic [7:0] b);
    return (b >= ChTab && b <= ChCr) || b == ChSpace;
  endfunction

  function automatic void put_res(logic [7:0] ch, logic has, logic [1:0] kind,
                                  logic tend, logic done);
    res_t r;
    r.ch = ch;
    r.has_char = has;
    r.kind = kind;
    r.tok_end = tend;
    r.done = done;
    r.last = 1'b0;
    if (step_res.size() < MaxResults) step_res.push_back(r);
  endfunction

  function automatic void keep_char(logic [7:0] ch, logic [1:0] kind);
    if (kept_cnt < char_limit) begin
      put_res(ch, 1'b1, kind, 1'b0, 1'b0);
      kept_cnt++;
    end
  endfunction

  function automatic void end_stream();
    put_res(ChEnd, 1'b0, KindWord, 1'b0, 1'b1);
    scan_st = ScIdle;
    kept_cnt = '0;
  endfunction

  function automatic void tok_start(logic [7:0] b);
    if (b == ChEnd) begin
      end_stream();
    end else if (is_ws(b)) begin
      scan_st = ScIdle;
    end else if (b == ChSlash) begin
      scan_st = ScSlash;
    end else if (b == ChLbrace || b == ChRbrace) begin
      put_res(b, 1'b1, KindBrace, 1'b0, 1'b0);
      put_res(ChEnd, 1'b0, KindBrace, 1'b1, 1'b0);
      scan_st = ScIdle;
    end else if (b == ChQuote) begin
      kept_cnt = '0;
      scan_st = ScQuote;
    end else begin
      kept_cnt = '0;
      scan_st = ScWord;
      keep_char(b, KindWord);
    end
  endfunction

  function automatic void word_byte(logic [7:0] b);
    if (b == ChEnd) begin
      put_res(ChEnd, 1'b0, KindWord, 1'b1, 1'b0);
      end_stream();
    end else if (is_ws(b) || b == ChLbrace || b == ChRbrace || b == ChQuote) begin
      put_res(ChEnd, 1'b0, KindWord, 1'b1, 1'b0);
      scan_st = ScIdle;
      tok_start(b);
    end else begin
      keep_char(b, KindWord);
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    step_res.delete();
    case (scan_st)
      ScSlash: begin
        if (b == ChSlash) begin
          scan_st = ScLine;
        end else if (b == ChStar) begin
          scan_st = ScBlock;
        end else begin
          kept_cnt = '0;
          scan_st = ScWord;
          keep_char(ChSlash, KindWord);
          word_byte(b);
        end
      end
      ScLine: begin
        if (b == ChEnd) end_stream();
        else if (b == ChNewline) scan_st = ScIdle;
      end
      ScBlock: begin
        if (b == ChEnd) end_stream();
        else if (b == ChStar) scan_st = ScBlockStar;
      end
      ScBlockStar: begin
        if (b == ChEnd) end_stream();
        else if (b == ChSlash) scan_st = ScIdle;
        else if (b != ChStar) scan_st = ScBlock;
      end
      ScWord: word_byte(b);
      ScQuote: begin
        if (b == ChEnd) begin
          put_res(ChEnd, 1'b0, KindQuote, 1'b1, 1'b0);
          end_stream();
        end else if (b == ChQuote || b == ChNewline) begin
          put_res(ChEnd, 1'b0, KindQuote, 1'b1, 1'b0);
          scan_st = ScIdle;
        end else begin
          keep_char(b, KindQuote);
        end
      end
      default: tok_start(b);
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(255, 33));
    while (c == ChLbrace || c == ChRbrace || c == ChQuote) c = 8'($urandom_range(255, 33));
    return c;
  endfunction

  function automatic logic [7:0] quote_char();
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    while (c == ChQuote || c == ChNewline) c = 8'($urandom_range(255, 1));
    return c;
  endfunction

  task automatic send_row(input dir_row_t row);
    int unsigned gap;
    gap = pick_gap(tx_pct);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    text_byte_i = row.b;
    do @(posedge clk_i); while (in_stall_o);
    scan_byte(row.b);
    byte_cnt++;
    if (row.typed) begin
      if (row.n > 0) tok_exp_q.push_back(row.r0);
      if (row.n > 1) tok_exp_q.push_back(row.r1);
    end else begin
      foreach (step_res[i]) tok_exp_q.push_back(step_res[i]);
    end
    @(negedge clk_i);
  endtask

  task automatic push_text(input logic [7:0] b);
    send_row({b, 1'b0, 3'd0, NoRes, NoRes});
  endtask

  task automatic write_limit(input logic [7:0] v);
    in_valid_i = 1'b0;
    while (tok_exp_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    char_limit = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly well-formed tokens with random content, separated by whitespace or
  // glued together, with some raw bytes mixed in; the buffer ends with a zero byte.
  task automatic gen_phase(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  c;
    start = byte_cnt;
    while (byte_cnt - start < n) begin
      pick = $urandom_range(19);
      if (pick < 6) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
        repeat (len) push_text(word_char());
      end else if (pick < 10) begin
        push_text(ChQuote);
        len = $urandom_range(8);
        repeat (len) push_text(quote_char());
        push_text(($urandom_range(3) == 0) ? ChNewline : ChQuote);
      end else if (pick < 13) begin
        push_text(($urandom_range(1) == 0) ? ChLbrace : ChRbrace);
      end else if (pick < 15) begin
        push_text(ChSlash);
        push_text(ChSlash);
        len = $urandom_range(5);
        repeat (len) push_text(quote_char());
        push_text(ChNewline);
      end else if (pick < 17) begin
        push_text(ChSlash);
        push_text(ChStar);
        len = $urandom_range(6);
        repeat (len) begin
          case ($urandom_range(2))
            0: push_text(ChStar);
            1: push_text(ChSlash);
            default: push_text(word_char());
          endcase
        end
        push_text(ChStar);
        push_text(ChSlash);
      end else if (pick < 18) begin
        push_text(ChSlash);
      end else begin
        push_text(8'($urandom_range(255)));
      end
      if ($urandom_range(3) != 0) begin
        c = 8'($urandom_range(14, 9));
        push_text((c == 8'd14) ? ChSpace : c);
      end
      if ($urandom_range(24) == 0) push_text(ChEnd);
    end
    push_text(ChEnd);
  endtask

  task automatic report_err(input string what, input int unsigned got,
                            input int unsigned want);
    err_cnt++;
    if (err_cnt <= MaxPrinted)
      $display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, want, res_cnt);
  endtask

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {token_char_o, has_char_o, token_kind_o, token_end_o, stream_done_o,
             last_of_step_o};
      if (tok_exp_q.size() == 0) begin
        report_err("result with no request waiting", 32'(got), 0);
      end else begin
        want = tok_exp_q.pop_front();
        if (got.ch !== want.ch)
          report_err("token_char", 32'(got.ch), 32'(want.ch));
        if (got.has_char !== want.has_char)
          report_err("has_char", 32'(got.has_char), 32'(want.has_char));
        if (got.kind !== want.kind)
          report_err("token_kind", 32'(got.kind), 32'(want.kind));
        if (got.tok_end !== want.tok_end)
          report_err("token_end", 32'(got.tok_end), 32'(want.tok_end));
        if (got.done !== want.done)
          report_err("stream_done", 32'(got.done), 32'(want.done));
        if (got.last !== want.last)
          report_err("last_of_step", 32'(got.last), 32'(want.last));
      end
      res_cnt++;
      if (got.tok_end) tok_cnt++;
      if (got.done) buf_cnt++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == StallLimit) begin
      $display("Timeout: no request moved for %0d cycles, %0d results outstanding.",
               StallLimit, tok_exp_q.size());
      $display("** script_tokenizer_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned gap;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_long = 1'b0;
      end
      gap = pick_gap(rx_pct);
      out_stall_i = (gap != 0);
      if (gap != 0) repeat (gap - 1) @(negedge clk_i);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_pct = 20;
    rx_pct = 20;
    foreach (DirRows[i]) send_row(DirRows[i]);

    write_limit(8'd0);
    tx_pct = 0;
    rx_pct = 0;
    gen_phase(50);

    write_limit(8'd1);
    tx_pct = 25;
    rx_pct = 25;
    gen_phase(50);

    // The receiver holds off while bytes keep coming, so the result buffer fills.
    write_limit(8'd3);
    tx_pct = 0;
    hold_long = 1'b1;
    gen_phase(60);

    write_limit(8'd255);
    tx_pct = 30;
    rx_pct = 30;
    gen_phase(60);

    write_limit(8'($urandom_range(16, 4)));
    gen_phase(60);

    write_limit(8'd254);
    tx_pct = 10;
    rx_pct = 40;
    gen_phase(50);

    in_valid_i = 1'b0;
    while (tok_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d text bytes and %0d results: %0d tokens, %0d buffer ends,",
             byte_cnt, res_cnt, tok_cnt, buf_cnt);
    $display("with limits 0, 1, 3, 254, 255 and one random, under random stalls on both sides.");
    if (err_cnt == 0) begin
      $display("** script_tokenizer_core: PASSED **");
    end else begin
      $display("%0d mismatches found.", err_cnt);
      $display("** script_tokenizer_core: FAILED **");
    end
    $finish;
  end

endmodule
